// ----- rtl/gregorian_date_add_days_core_defines.svh -----
// Assertion macros shared by the date adder RTL.
`ifndef GREGORIAN_DATE_ADD_DAYS_CORE_DEFINES_SVH
`define GREGORIAN_DATE_ADD_DAYS_CORE_DEFINES_SVH

// Same-cycle implication, checked on clock, disabled in reset
`define GDA_ASSERT_NOW(lbl, ant, con, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |-> (con)) else $error(msg);

// Next-cycle implication, checked on clock, disabled in reset
`define GDA_ASSERT_NEXT(lbl, ant, con, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |=> (con)) else $error(msg);

`endif

// ----- rtl/gda_pkg.sv -----
// Shared types, calendar constants and month-length helpers for the date adder.
package gda_pkg;

   localparam int DAY_BITS   = 5;
   localparam int MONTH_BITS = 4;
   localparam int MOD_BITS   = 9;

   // Leap cycle of the Gregorian calendar and its century marks
   localparam logic [MOD_BITS-1:0] CYCLE_YEARS = 9'd400;
   localparam logic [MOD_BITS-1:0] CENTURY_1   = 9'd100;
   localparam logic [MOD_BITS-1:0] CENTURY_2   = 9'd200;
   localparam logic [MOD_BITS-1:0] CENTURY_3   = 9'd300;
   localparam logic [MOD_BITS-1:0] CYCLE_LAST  = CYCLE_YEARS - 9'd1;

   localparam logic [MONTH_BITS-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_BITS-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_BITS-1:0] MONTH_APR = 4'd4;
   localparam logic [MONTH_BITS-1:0] MONTH_JUN = 4'd6;
   localparam logic [MONTH_BITS-1:0] MONTH_SEP = 4'd9;
   localparam logic [MONTH_BITS-1:0] MONTH_NOV = 4'd11;
   localparam logic [MONTH_BITS-1:0] MONTH_DEC = 4'd12;

   localparam logic [DAY_BITS-1:0] DAYS_FEB  = 5'd28;
   localparam logic [DAY_BITS-1:0] DAYS_LEAP = 5'd29;
   localparam logic [DAY_BITS-1:0] DAYS_30   = 5'd30;
   localparam logic [DAY_BITS-1:0] DAYS_31   = 5'd31;
   localparam logic [DAY_BITS-1:0] DAY_FIRST = 5'd1;

   // Status from the year reducer to the sequencer
   typedef struct packed {
      logic                done;
      logic [MOD_BITS-1:0] rem;
   } red_status_type;

   // Leap year from the low year bits and the year modulo 400
   function automatic logic is_leap(input logic [1:0] y_low, input logic [MOD_BITS-1:0] y_mod);
      is_leap = (y_low == 2'd0) && (y_mod != CENTURY_1) && (y_mod != CENTURY_2) &&
                (y_mod != CENTURY_3);
   endfunction

   // Days in a month (month already clamped to 1..12)
   function automatic logic [DAY_BITS-1:0] month_len(input logic [MONTH_BITS-1:0] m,
                                                     input logic leap);
      logic [DAY_BITS-1:0] n;
      case (m)
         MONTH_FEB: n = leap ? DAYS_LEAP : DAYS_FEB;
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: n = DAYS_30;
         default: n = DAYS_31;
      endcase
      month_len = n;
   endfunction

endpackage

// ----- rtl/gregorian_date_add_days_core.sv -----
// Gregorian date adder: sequencer, month stepper and result register.
// Adds add_count days to a Gregorian date one month boundary per cycle. After
// a transaction is accepted the year is reduced modulo 400 by a reciprocal
// multiply, the start day is clamped, one month is crossed per step, a last
// step finishes the in-month part (or sees the count used up), and the result
// register is loaded. req_tready is thus low from acceptance until the result
// register is loaded; a result still waiting in the output register stretches
// this wait. A start month of 0 reads as January, 13..15 as December; a start
// day of 0 reads as 1 and a day past the month end as the last day. When the
// year would pass its top value it holds there and year_overflow is set. The
// finished result sits in an output register, so a new transaction may be
// taken while it waits.
`include "gregorian_date_add_days_core_defines.svh"

module gregorian_date_add_days_core #(
   parameter int YEAR_BITS  = 14,
   parameter int COUNT_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // start_day[4:0], start_month[8:5], start_year, add_count, zero pad
   input  logic [(((9 + YEAR_BITS + COUNT_BITS) + 7) / 8) * 8 - 1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // end_day[4:0], end_month[8:5], end_year, year_overflow, zero pad
   output logic [(((10 + YEAR_BITS) + 7) / 8) * 8 - 1:0] rsp_tdata
);
   import gda_pkg::*;

   localparam int OUT_W = (((10 + YEAR_BITS) + 7) / 8) * 8;
   localparam int Y_LSB = DAY_BITS + MONTH_BITS;
   localparam int C_LSB = Y_LSB + YEAR_BITS;
   localparam logic [YEAR_BITS-1:0] YEAR_MAX = {YEAR_BITS{1'b1}};

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_REDUCE = 3'd1;
   localparam logic [2:0] ST_CLAMP  = 3'd2;
   localparam logic [2:0] ST_STEP   = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [DAY_BITS-1:0]   d_ff, d_in;
   logic [MONTH_BITS-1:0] m_ff, m_in;
   logic [YEAR_BITS-1:0]  y_ff, y_in;
   logic [COUNT_BITS-1:0] rem_ff, rem_in;
   logic [MOD_BITS-1:0]   mod_ff, mod_in;
   logic                  ovf_ff, ovf_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]      rsp_data_ff, rsp_data_in;

   logic                  accept_w;
   logic [MONTH_BITS-1:0] start_month_w;
   logic                  leap_w;
   logic [DAY_BITS-1:0]   len_w;
   logic [DAY_BITS-1:0]   left_w;
   red_status_type        red_status;
   logic                  day_ok_w;
   logic                  rsp_month_ok_w;
   logic                  rsp_sat_ok_w;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept_w   = req_tvalid && req_tready;

   // Year reducer for the leap test
   gda_mod400 #(
      .YEAR_BITS (YEAR_BITS)
   ) u_mod400 (
      .clock  (clock),
      .reset  (reset),
      .start  (accept_w),
      .year   (req_tdata[Y_LSB +: YEAR_BITS]),
      .status (red_status)
   );

   // Month clamp on the incoming field
   always_comb begin
      start_month_w = req_tdata[DAY_BITS +: MONTH_BITS];
      if (start_month_w == '0) begin
         start_month_w = MONTH_JAN;
      end else if (start_month_w > MONTH_DEC) begin
         start_month_w = MONTH_DEC;
      end
   end

   // Current month length and days left in it
   assign leap_w = is_leap(y_ff[1:0], mod_ff);
   assign len_w  = month_len(m_ff, leap_w);
   assign left_w = len_w - d_ff;

   // Sequencer and month stepper
   always_comb begin
      state_in     = state_ff;
      d_in         = d_ff;
      m_in         = m_ff;
      y_in         = y_ff;
      rem_in       = rem_ff;
      mod_in       = mod_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept_w) begin
               d_in     = req_tdata[DAY_BITS-1:0];
               m_in     = start_month_w;
               y_in     = req_tdata[Y_LSB +: YEAR_BITS];
               rem_in   = req_tdata[C_LSB +: COUNT_BITS];
               ovf_in   = 1'b0;
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (red_status.done) begin
               mod_in   = red_status.rem;
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            if (d_ff == '0) begin
               d_in = DAY_FIRST;
            end else if (d_ff > len_w) begin
               d_in = len_w;
            end
            state_in = ST_STEP;
         end
         ST_STEP: begin
            if (rem_ff == '0) begin
               state_in = ST_DONE;
            end else if (rem_ff > COUNT_BITS'(left_w)) begin
               // Cross into the next month
               rem_in = rem_ff - COUNT_BITS'({1'b0, left_w} + 6'd1);
               d_in   = DAY_FIRST;
               if (m_ff == MONTH_DEC) begin
                  m_in = MONTH_JAN;
                  if (y_ff == YEAR_MAX) begin
                     ovf_in = 1'b1;
                  end else begin
                     y_in   = y_ff + 1'b1;
                     mod_in = (mod_ff == CYCLE_LAST) ? '0 : mod_ff + 1'b1;
                  end
               end else begin
                  m_in = m_ff + 1'b1;
               end
            end else begin
               // Remainder fits in this month
               d_in     = d_ff + rem_ff[DAY_BITS-1:0];
               rem_in   = '0;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = OUT_W'({ovf_ff, y_ff, m_ff, d_ff});
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      d_ff        <= d_in;
      m_ff        <= m_in;
      y_ff        <= y_in;
      rem_ff      <= rem_in;
      mod_ff      <= mod_in;
      ovf_ff      <= ovf_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Checks
   assign day_ok_w       = (d_ff != '0) && (d_ff <= len_w);
   assign rsp_month_ok_w = (rsp_tdata[DAY_BITS +: MONTH_BITS] != '0) &&
                           (rsp_tdata[DAY_BITS +: MONTH_BITS] <= MONTH_DEC);
   assign rsp_sat_ok_w   = !rsp_tdata[Y_LSB + YEAR_BITS] ||
                           (rsp_tdata[Y_LSB +: YEAR_BITS] == YEAR_MAX);

   `GDA_ASSERT_NEXT(a_busy_after_accept, accept_w, !req_tready, "ready high after accept")
   `GDA_ASSERT_NOW(a_day_in_month, state_ff == ST_STEP, day_ok_w, "day outside month")
   `GDA_ASSERT_NOW(a_rsp_month_range, rsp_tvalid, rsp_month_ok_w, "result month out of range")
   `GDA_ASSERT_NOW(a_ovf_saturates, rsp_tvalid, rsp_sat_ok_w, "overflow without saturated year")

endmodule

// ----- rtl/gda_mod400.sv -----
// Year-modulo-400 reducer: reciprocal multiply, then multiply back and subtract.
module gda_mod400 #(
   parameter int YEAR_BITS = 14
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [YEAR_BITS-1:0]     year,
   output gda_pkg::red_status_type  status
);
   import gda_pkg::*;

   // floor(year / 400) = (year * RECIP) >> SHIFT for every YEAR_BITS-wide year
   localparam int SHIFT      = YEAR_BITS + MOD_BITS;
   localparam int RECIP_BITS = YEAR_BITS + 1;
   localparam int PROD_BITS  = YEAR_BITS + RECIP_BITS;
   localparam int QUOT_BITS  = YEAR_BITS - 8;
   localparam logic [RECIP_BITS-1:0] RECIP =
      RECIP_BITS'(((64'd1 << SHIFT) + 64'(CYCLE_LAST)) / 64'(CYCLE_YEARS));

   logic [YEAR_BITS-1:0] year_ff, year_in;
   logic [QUOT_BITS-1:0] quot_ff, quot_in;
   logic [MOD_BITS-1:0]  rem_ff, rem_in;
   logic                 mul_step_ff, mul_step_in;
   logic                 sub_step_ff, sub_step_in;
   logic                 done_ff, done_in;
   logic [PROD_BITS-1:0] prod_w;
   logic [YEAR_BITS-1:0] back_w;
   logic [MOD_BITS-1:0]  diff_w;

   // Quotient estimate, then the year less 400 times the quotient
   assign prod_w = PROD_BITS'(year_ff) * PROD_BITS'(RECIP);
   assign back_w = YEAR_BITS'(quot_ff) * YEAR_BITS'(CYCLE_YEARS);
   assign diff_w = MOD_BITS'(year_ff - back_w);

   // Next-state logic: load, multiply, subtract
   always_comb begin
      year_in     = year_ff;
      quot_in     = quot_ff;
      rem_in      = rem_ff;
      mul_step_in = start;
      sub_step_in = mul_step_ff;
      done_in     = sub_step_ff;
      if (start) begin
         year_in = year;
      end
      if (mul_step_ff) begin
         quot_in = prod_w[SHIFT +: QUOT_BITS];
      end
      if (sub_step_ff) begin
         rem_in = diff_w;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mul_step_ff <= 1'b0;
         sub_step_ff <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         mul_step_ff <= mul_step_in;
         sub_step_ff <= sub_step_in;
         done_ff     <= done_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      year_ff <= year_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign status.done = done_ff;
   assign status.rem  = rem_ff;

endmodule

// ----- test/gregorian_date_add_days_core_test.sv -----
// Self-checking testbench for the Gregorian date adder core.
module gregorian_date_add_days_core_test;
   import gda_pkg::*;

   localparam int YEAR_BITS  = 14;
   localparam int COUNT_BITS = 16;
   localparam int REQ_FIELDS = 9 + YEAR_BITS + COUNT_BITS;
   localparam int REQ_W      = ((REQ_FIELDS + 7) / 8) * 8;
   localparam int RSP_W      = (((10 + YEAR_BITS) + 7) / 8) * 8;
   localparam int YEAR_TOP   = (1 << YEAR_BITS) - 1;
   localparam int COUNT_TOP  = (1 << COUNT_BITS) - 1;
   localparam int DRAIN_CYCLES = 2500;   // worst-case walk through one count
   localparam int HOLD_CYCLES  = 3000;   // long receiver stall, longer than one item

   // One start date plus count; drain_first makes the sender wait for an empty pipe
   typedef struct {
      logic [DAY_BITS-1:0]   day;
      logic [MONTH_BITS-1:0] month;
      logic [YEAR_BITS-1:0]  year;
      logic [COUNT_BITS-1:0] count;
      logic                  drain_first;
   } date_req_type;

   typedef struct {
      logic [DAY_BITS-1:0]   day;
      logic [MONTH_BITS-1:0] month;
      logic [YEAR_BITS-1:0]  year;
      logic                  overflow;
   } date_res_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   date_req_type dates_to_send[$];
   date_res_type dates_due[$];
   int        num_dates = 0;
   int        dates_sent = 0;
   int        dates_seen = 0;
   int        mismatch_count = 0;

   logic      rx_hold_active = 1'b0;
   logic      rx_hold_done = 1'b0;
   int        rx_hold_left = 0;

   gregorian_date_add_days_core #(
      .YEAR_BITS (YEAR_BITS),
      .COUNT_BITS(COUNT_BITS)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Gregorian leap rule
   function automatic logic leap_year(input logic [YEAR_BITS-1:0] y);
      int unsigned yi;
      yi = y;
      leap_year = (yi % 4 == 0) && ((yi % 100 != 0) || (yi % 400 == 0));
   endfunction

   function automatic int unsigned days_in(input logic [MONTH_BITS-1:0] m,
                                           input logic [YEAR_BITS-1:0] y);
      int unsigned n;
      case (m)
         MONTH_FEB: n = leap_year(y) ? 29 : 28;
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: n = 30;
         default: n = 31;
      endcase
      days_in = n;
   endfunction

   // Expected end date: clamp the start, then walk the count month by month
   function automatic date_res_type predict_end_date(input date_req_type r);
      date_res_type res;
      int unsigned d;
      int unsigned mlen;
      int unsigned left_days;
      int unsigned rem;
      logic [MONTH_BITS-1:0] m;
      logic [YEAR_BITS-1:0]  y;
      logic ovf;
      m = r.month;
      y = r.year;
      d = r.day;
      rem = r.count;
      ovf = 1'b0;
      if (m < MONTH_JAN) m = MONTH_JAN;
      if (m > MONTH_DEC) m = MONTH_DEC;
      mlen = days_in(m, y);
      if (d < 1) d = 1;
      if (d > mlen) d = mlen;
      while (rem > 0) begin
         mlen = days_in(m, y);
         left_days = mlen - d;
         if (rem > left_days) begin
            rem = rem - (left_days + 1);
            d = 1;
            if (m == MONTH_DEC) begin
               m = MONTH_JAN;
               if (y == YEAR_TOP[YEAR_BITS-1:0]) ovf = 1'b1;
               else y = y + 1'b1;
            end else begin
               m = m + 1'b1;
            end
         end else begin
            d = d + rem;
            rem = 0;
         end
      end
      res.day = d[DAY_BITS-1:0];
      res.month = m;
      res.year = y;
      res.overflow = ovf;
      predict_end_date = res;
   endfunction

   function automatic date_req_type make_date(input int d, input int m, input int y, input int c);
      date_req_type r;
      r.day = DAY_BITS'(d);
      r.month = MONTH_BITS'(m);
      r.year = YEAR_BITS'(y);
      r.count = COUNT_BITS'(c);
      r.drain_first = 1'b0;
      make_date = r;
   endfunction

   function automatic date_req_type random_date();
      date_req_type r;
      int        pick;
      r.day   = DAY_BITS'(($urandom_range(99) < 85) ? $urandom_range(31, 1)
                                                    : $urandom_range(31));
      r.month = MONTH_BITS'(($urandom_range(99) < 85) ? $urandom_range(12, 1)
                                                      : $urandom_range(15));
      pick = $urandom_range(99);
      if (pick < 70) r.year = YEAR_BITS'($urandom_range(YEAR_TOP));
      else if (pick < 80) r.year = YEAR_BITS'($urandom_range(YEAR_TOP, YEAR_TOP - 13));
      else r.year = YEAR_BITS'(100 * $urandom_range(YEAR_TOP / 100));
      // mostly short walks; a few full-range counts
      r.count = COUNT_BITS'(($urandom_range(99) < 10) ? $urandom_range(COUNT_TOP)
                                                      : $urandom_range(1500));
      r.drain_first = 1'b0;
      random_date = r;
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Driver: offers queued transactions, holds tvalid until accepted
   always @(posedge clock) begin
      logic took;
      logic offer;
      date_req_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else begin
         took = req_tvalid && req_tready;
         offer = 1'b0;
         if (took) begin
            dates_due.push_back(predict_end_date(dates_to_send.pop_front()));
            dates_sent <= dates_sent + 1;
         end
         if (!(req_tvalid && !took)) begin
            if (dates_to_send.size() != 0) begin
               nxt = dates_to_send[0];
               if (nxt.drain_first && (dates_sent + took != dates_seen))
                  offer = 1'b0;
               else if (dates_sent >= 60 && dates_sent < 110)
                  offer = 1'b1;
               else
                  offer = ($urandom_range(99) >= 28);
               if (offer)
                  req_tdata <= {{(REQ_W - REQ_FIELDS){1'b0}}, nxt.count, nxt.year,
                                nxt.month, nxt.day};
            end
            req_tvalid <= offer;
         end
      end
   end

   // Monitor: checks each result against the oldest expected date
   always @(posedge clock) begin
      date_res_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            dates_seen <= dates_seen + 1;
            if (dates_due.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h", $time, rsp_tdata);
               mismatch_count++;
            end else begin
               want = dates_due.pop_front();
               check_field("end_day", want.day, rsp_tdata[4:0]);
               check_field("end_month", want.month, rsp_tdata[8:5]);
               check_field("end_year", want.year, rsp_tdata[9 +: YEAR_BITS]);
               check_field("year_overflow", want.overflow, rsp_tdata[9 + YEAR_BITS]);
            end
         end
         if (rx_hold_active)
            rsp_tready <= 1'b0;
         else if (dates_seen >= 120 && dates_seen < 170)
            rsp_tready <= 1'b1;
         else
            rsp_tready <= ($urandom_range(99) >= 28);
      end
   end

   // Long receiver stall, once, so the core fills and backs up its input
   always @(posedge clock) begin
      if (reset) begin
         rx_hold_active <= 1'b0;
         rx_hold_left   <= 0;
         rx_hold_done   <= 1'b0;
      end else if (rx_hold_active) begin
         if (rx_hold_left == 0) rx_hold_active <= 1'b0;
         else rx_hold_left <= rx_hold_left - 1;
      end else if (!rx_hold_done && dates_seen == 30) begin
         rx_hold_active <= 1'b1;
         rx_hold_left   <= HOLD_CYCLES;
         rx_hold_done   <= 1'b1;
      end
   end

   // Stimulus, reset and end of run
   initial begin
      date_req_type r;
      // clamping of day and month, zero count
      dates_to_send.push_back(make_date(0, 0, 0, 0));
      dates_to_send.push_back(make_date(31, 15, YEAR_TOP, 0));
      dates_to_send.push_back(make_date(31, 13, 400, 31));
      dates_to_send.push_back(make_date(31, 4, 5, 10));
      // leap rule: 400-year, century and plain years
      dates_to_send.push_back(make_date(31, 2, 2000, 0));
      dates_to_send.push_back(make_date(31, 2, 1900, 0));
      dates_to_send.push_back(make_date(29, 2, 0, 0));
      dates_to_send.push_back(make_date(29, 2, YEAR_TOP, 0));
      dates_to_send.push_back(make_date(28, 2, 2024, 1));
      dates_to_send.push_back(make_date(28, 2, 2023, 1));
      dates_to_send.push_back(make_date(29, 2, 16000, 366));
      // year rollover and saturation at the top year
      dates_to_send.push_back(make_date(31, 12, 1999, 1));
      dates_to_send.push_back(make_date(31, 12, YEAR_TOP, 1));
      dates_to_send.push_back(make_date(1, 1, YEAR_TOP - 3, COUNT_TOP));
      dates_to_send.push_back(make_date(15, 6, 2100, COUNT_TOP));
      dates_to_send.push_back(make_date(31, 1, 8191, 365));
      dates_to_send.push_back(make_date(30, 11, YEAR_TOP, 400));
      dates_to_send.push_back(make_date(1, 3, 2099, 0));
      for (int i = 0; i < 250; i++) begin
         r = random_date();
         r.drain_first = (i == 150);
         dates_to_send.push_back(r);
      end
      num_dates = dates_to_send.size();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (dates_seen < num_dates) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (dates_due.size() != 0) begin
         $display("%0t: %0d results missing, expected %0d more, actual 0", $time,
                  dates_due.size(), dates_due.size());
         mismatch_count++;
      end
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // Watchdog
   initial begin
      #(12 * 4000000);
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// ----- gregorian_date_add_days_core.f -----
+incdir+rtl
rtl/gda_pkg.sv
rtl/gda_mod400.sv
rtl/gregorian_date_add_days_core.sv
test/gregorian_date_add_days_core_test.sv
